// ----- sv/murmur_hash_64_engine_core_assert.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the murmur hash core
// Implication and next-cycle checks on a clock with a synchronous reset.
// -----------------------------------------------------------------------------
`ifndef MURMUR_HASH_64_ENGINE_CORE_ASSERT_SVH
`define MURMUR_HASH_64_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define MH64_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define MH64_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- sv/mh64_pkg.sv -----
// -----------------------------------------------------------------------------
// mh64_pkg
// Constants and shared types of the 64-bit murmur hash core.
// -----------------------------------------------------------------------------
`default_nettype none

package mh64_pkg;

  localparam logic [63:0] MH_MUL  = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MH_SEED = 64'hdeadbeefdeadbeef;
  localparam int unsigned MH_SHIFT = 47;

  localparam logic [31:0] MH_MUL_LO = MH_MUL[31:0];
  localparam logic [31:0] MH_MUL_HI = MH_MUL[63:32];

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ----- sv/mh64_if.sv -----
// -----------------------------------------------------------------------------
// mh64_if
// Valid/ready channels for key words in and hash results out.
// -----------------------------------------------------------------------------
`default_nettype none

interface mh64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic [31:0] key_length;
  logic        last_word;

  modport source (output valid, data_word, valid_bytes, key_length, last_word,
                  input ready);
  modport sink   (input valid, data_word, valid_bytes, key_length, last_word,
                  output ready);
endinterface

interface mh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

// ----- sv/mh64_mul.sv -----
// -----------------------------------------------------------------------------
// mh64_mul
// Multiplies a 64-bit operand by the hash constant, modulo 2^64, with one
// 32x32 multiplier, one partial product at a time.
// -----------------------------------------------------------------------------
`default_nettype none

`include "murmur_hash_64_engine_core_assert.svh"

module mh64_mul
  import mh64_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  localparam logic [1:0] STEP_LL = 2'd0;  // a_lo * m_lo
  localparam logic [1:0] STEP_HL = 2'd1;  // a_hi * m_lo
  localparam logic [1:0] STEP_LH = 2'd2;  // a_lo * m_hi

  logic [63:0] a;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        run;
  logic        done;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  always_comb begin
    op_a = (step == STEP_HL) ? a[63:32] : a[31:0];
    op_b = (step == STEP_LH) ? MH_MUL_HI : MH_MUL_LO;
    prod = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= STEP_LL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a    <= req.operand;
        step <= STEP_LL;
        run  <= 1'b1;
      end else if (run) begin
        if (step == STEP_LL) begin
          acc <= prod;
        end else begin
          acc <= acc + {prod[31:0], 32'b0};
        end
        if (step == STEP_LH) begin
          run  <= 1'b0;
          done <= 1'b1;
          step <= STEP_LL;
        end else begin
          step <= step + 2'd1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

  `MH64_ASSERT_IMP(a_start_when_free, clk, rst, req.start, !run)
  `MH64_ASSERT_NXT(a_last_step_done, clk, rst, run && (step == STEP_LH), done && !run)
  `MH64_ASSERT_NXT(a_start_runs, clk, rst, req.start, run && (step == STEP_LL))

endmodule

`default_nettype wire

// ----- sv/murmur_hash_64_engine_core.sv -----
// A first word adds one multiply pass for the length seed; a last word adds
// the tail/full mix and the final avalanche multiply.
// Every 64-bit multiply runs on the shared 32x32 multiplier.
// The result sits in an output register, so a new word is taken while it waits.
// Reset (rst, synchronous): idle, no key in progress, running hash zero.
// -----------------------------------------------------------------------------
// murmur_hash_64_engine_core
// 64-bit murmur hash (64A) over a key streamed as little-endian 64-bit words.
// -----------------------------------------------------------------------------
`default_nettype none

`include "murmur_hash_64_engine_core_assert.svh"

module murmur_hash_64_engine_core
  import mh64_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  mh64_in_if.sink    key_in,
  mh64_out_if.source hash_out
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SEED     = 9'b000000010,
    S_DISPATCH = 9'b000000100,
    S_K1       = 9'b000001000,
    S_K2       = 9'b000010000,
    S_HMUL     = 9'b000100000,
    S_TAIL     = 9'b001000000,
    S_FIN      = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
  localparam logic [3:0] NO_BYTES        = 4'd0;

  function automatic logic [63:0] xorshift(input logic [63:0] x);
    xorshift = x ^ (x >> MH_SHIFT);
  endfunction

  function automatic logic [63:0] tail_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[i*8 +: 8] = 8'hff;
    end
    tail_mask = m;
  endfunction

  state_t      state;
  logic        in_progress;
  logic [63:0] h;
  logic [63:0] word;
  logic [3:0]  cnt;
  logic        last;
  logic        go;
  logic        go_next;
  logic [63:0] opnd;
  logic        out_valid;
  logic [63:0] out_hash;

  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  logic        in_xfer;
  logic [3:0]  cnt_sat;
  logic        mul_wait;
  logic        out_load;

  assign mul_req.start   = go;
  assign mul_req.operand = opnd;

  mh64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign key_in.ready        = (state == S_IDLE);
  assign in_xfer             = key_in.valid && key_in.ready;
  assign cnt_sat             = key_in.valid_bytes[3] ? FULL_WORD_BYTES : key_in.valid_bytes;
  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = out_hash;

  assign mul_wait = (state == S_SEED) || (state == S_K1) || (state == S_K2) ||
                    (state == S_HMUL) || (state == S_TAIL) || (state == S_FIN);
  assign out_load = (state == S_DONE) && (!out_valid || hash_out.ready);

  // multiply start pulse, issued on the edge that leaves each launching state
  always_comb begin
    go_next = 1'b0;
    unique case (state)
      S_IDLE:     go_next = key_in.valid && !in_progress;
      S_DISPATCH: go_next = 1'b1;
      S_K1:       go_next = mul_rsp.done;
      S_K2:       go_next = mul_rsp.done;
      S_HMUL:     go_next = mul_rsp.done && last;
      S_TAIL:     go_next = mul_rsp.done;
      default:    go_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      in_progress <= 1'b0;
      h           <= '0;
      go          <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      go <= go_next;
      if (out_valid && hash_out.ready && (state != S_DONE)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (key_in.valid) begin
            word <= key_in.data_word;
            cnt  <= cnt_sat;
            last <= key_in.last_word;
            if (in_progress) begin
              state <= S_DISPATCH;
            end else begin
              opnd  <= {32'b0, key_in.key_length};
              state <= S_SEED;
            end
          end
        end
        S_SEED: begin
          if (mul_rsp.done) begin
            h     <= MH_SEED ^ mul_rsp.product;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (!last || cnt == FULL_WORD_BYTES) begin
            opnd  <= word;
            state <= S_K1;
          end else if (cnt != NO_BYTES) begin
            opnd  <= h ^ (word & tail_mask(cnt));
            state <= S_TAIL;
          end else begin
            opnd  <= xorshift(h);
            state <= S_FIN;
          end
        end
        S_K1: begin
          if (mul_rsp.done) begin
            opnd  <= xorshift(mul_rsp.product);
            state <= S_K2;
          end
        end
        S_K2: begin
          if (mul_rsp.done) begin
            opnd  <= h ^ mul_rsp.product;
            state <= S_HMUL;
          end
        end
        S_HMUL: begin
          if (mul_rsp.done) begin
            h <= mul_rsp.product;
            if (last) begin
              opnd  <= xorshift(mul_rsp.product);
              state <= S_FIN;
            end else begin
              in_progress <= 1'b1;
              state       <= S_IDLE;
            end
          end
        end
        S_TAIL: begin
          if (mul_rsp.done) begin
            opnd  <= xorshift(mul_rsp.product);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (mul_rsp.done) begin
            h     <= xorshift(mul_rsp.product);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || hash_out.ready) begin
            out_valid   <= 1'b1;
            out_hash    <= h;
            in_progress <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MH64_ASSERT_IMP(a_done_in_mul_state, clk, rst, mul_rsp.done, mul_wait)
  `MH64_ASSERT_NXT(a_new_key_seeds, clk, rst, in_xfer && !in_progress, (state == S_SEED) && go)
  `MH64_ASSERT_NXT(a_cont_key_mixes, clk, rst, in_xfer && in_progress, state == S_DISPATCH)
  `MH64_ASSERT_NXT(a_result_load, clk, rst, out_load, out_valid && (out_hash == $past(h)))

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench
// Streams keys into the 64-bit murmur hash core and checks each finished hash
// against a word-by-word software hash kept in a scoreboard. Starts with a
// directed set of corner cases, then random keys that are mostly well formed,
// with random idle gaps on the key input and random stalls on the hash output.
// -----------------------------------------------------------------------------

module testbench;
  import mh64_pkg::*;

  localparam int unsigned TOTAL_WORDS = 1100;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 40;

  class key_hash_board;
    logic [63:0] running_hash;
    bit          key_open;
    logic [63:0] expected_hashes[$];
    int          mismatches;

    function new();
      running_hash = '0;
      key_open = 1'b0;
      mismatches = 0;
    endfunction

    function logic [63:0] mix_word(logic [63:0] h, logic [63:0] w);
      logic [63:0] k;
      k = w * MH_MUL;
      k = k ^ (k >> MH_SHIFT);
      k = k * MH_MUL;
      h = h ^ k;
      return h * MH_MUL;
    endfunction

    function void note_word(logic [63:0] word, logic [3:0] count, logic [31:0] len,
                            logic last);
      logic [63:0] h;
      logic [63:0] mask;
      if (key_open) begin
        h = running_hash;
      end else begin
        h = MH_SEED ^ ({32'd0, len} * MH_MUL);
      end
      if (!last) begin
        running_hash = mix_word(h, word);
        key_open = 1'b1;
        return;
      end
      if (count >= 4'd8) begin
        h = mix_word(h, word);
      end else if (count != 4'd0) begin
        mask = (64'd1 << (8 * count)) - 64'd1;
        h = h ^ (word & mask);
        h = h * MH_MUL;
      end
      h = h ^ (h >> MH_SHIFT);
      h = h * MH_MUL;
      h = h ^ (h >> MH_SHIFT);
      running_hash = h;
      key_open = 1'b0;
      expected_hashes.push_back(h);
    endfunction

    function void check_hash(logic [63:0] actual);
      logic [63:0] want;
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, actual);
        mismatches++;
        return;
      end
      want = expected_hashes.pop_front();
      if (actual !== want) begin
        $display("%0t: hash mismatch, expected %h, actual %h", $time, want, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;

  key_hash_board hashes = new();

  mh64_in_if  key_if ();
  mh64_out_if hash_if ();

  murmur_hash_64_engine_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .key_in   (key_if),
    .hash_out (hash_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                           input logic [31:0] len, input logic last);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_if.valid       <= 1'b1;
    key_if.data_word   <= word;
    key_if.valid_bytes <= count;
    key_if.key_length  <= len;
    key_if.last_word   <= last;
    do @(posedge clk); while (!key_if.ready);
    hashes.note_word(word, count, len, last);
    words_sent++;
  endtask

  task automatic send_key(input logic [31:0] len, input int unsigned words,
                          input logic [3:0] tail);
    for (int unsigned i = 0; i + 1 < words; i++) begin
      send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                (i == 0) ? len : 32'($urandom), 1'b0);
    end
    send_word({$urandom, $urandom}, tail, (words == 1) ? len : 32'($urandom), 1'b1);
  endtask

  task automatic wait_drained();
    key_if.valid <= 1'b0;
    while (hashes.pending() != 0) @(posedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    hash_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      int unsigned gap;
      gap = idle_cycles();
      if (gap > 0) begin
        hash_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hash_if.ready <= 1'b1;
      do @(posedge clk); while (!hash_if.valid);
      hashes.check_hash(hash_if.hash_value);
    end
  end

  initial begin
    logic [31:0] key_len;
    int unsigned words;
    logic [3:0]  tail;
    int unsigned pick;

    key_if.valid       <= 1'b0;
    key_if.data_word   <= '0;
    key_if.valid_bytes <= '0;
    key_if.key_length  <= '0;
    key_if.last_word   <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty keys, stray data ignored
    send_word('0, 4'd0, 32'd0, 1'b1);
    send_word('1, 4'd0, 32'hffffffff, 1'b1);
    // single-word keys, every tail size, bytes above the count ignored
    for (int c = 1; c <= 8; c++) begin
      send_word('1, 4'(c), 32'(c), 1'b1);
    end
    // counts above eight saturate
    send_word('1, 4'd9, 32'd8, 1'b1);
    send_word('1, 4'd15, 32'd8, 1'b1);
    send_word(64'h0706050403020100, 4'd8, 32'd8, 1'b1);
    // inner counts and later lengths ignored
    send_word('1, 4'd0, 32'hffffffff, 1'b0);
    send_word(64'h8000000000000001, 4'd15, 32'h12345678, 1'b0);
    send_word('1, 4'd3, 32'd0, 1'b1);
    // claimed length disagrees with what is delivered
    send_word({$urandom, $urandom}, 4'd5, 32'd5, 1'b0);
    send_word({$urandom, $urandom}, 4'd1, 32'd77, 1'b0);
    send_word({$urandom, $urandom}, 4'd5, 32'd5, 1'b1);

    wait_drained();

    while (words_sent < TOTAL_WORDS) begin
      pick = $urandom_range(0, 99);
      steady = ($urandom_range(0, 7) == 0);
      if (pick < 70) begin
        key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 240)
                                              : $urandom_range(0, 40);
        words = (key_len == 0) ? 1 : (key_len + 7) / 8;
        tail = (key_len == 0) ? 4'd0 : ((key_len % 8 == 0) ? 4'd8 : 4'(key_len % 8));
      end else if (pick < 85) begin
        key_len = $urandom;
        words = $urandom_range(1, 6);
        tail = 4'($urandom_range(0, 8));
      end else begin
        key_len = $urandom;
        words = $urandom_range(1, 3);
        tail = 4'($urandom_range(0, 15));
      end
      send_key(key_len, words, tail);
      if ($urandom_range(0, 49) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (hashes.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
